### hdl/sgm_pkg.sv
// shared constants, types and helpers for the sobel gradient magnitude block
package sgm_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam int unsigned CFG_BITS   = 12;
  localparam int unsigned PADDR_BITS = 3;
  localparam int unsigned DATA_BITS  = 32;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

  // width holds 1..MAX_WIDTH, height holds 0..MAX_HEIGHT (input row may reach h)
  localparam int unsigned WID_BITS = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_BITS = $clog2(MAX_HEIGHT + 1);

  // raster index plus the lookahead of one row and two pixels
  localparam int unsigned IDX_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

  // line store must hold two rows and three pixels of history
  localparam int unsigned LS_ABITS = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned LS_DEPTH = 1 << LS_ABITS;

  localparam int unsigned PIX_BITS  = 8;
  localparam int unsigned GRAD_BITS = 12;

  localparam logic signed [2:0] MASK_X [9] =
    '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1};
  localparam logic signed [2:0] MASK_Y [9] =
    '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1};

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [WID_BITS-1:0] width;
    logic [HGT_BITS-1:0] height;
  } geom_t;

  typedef logic [8:0][PIX_BITS-1:0] win_t;

  typedef struct packed {
    logic                done;
    logic [PIX_BITS-1:0] magnitude;
  } mag_res_t;

  typedef struct packed {
    logic                valid;
    logic [PIX_BITS-1:0] magnitude;
    logic                last;
  } res_t;

  function automatic logic [WID_BITS-1:0] eff_width(input logic [CFG_BITS-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x == 0) x = 1;
    else if (x > MAX_WIDTH) x = MAX_WIDTH;
    return WID_BITS'(x);
  endfunction

  function automatic logic [HGT_BITS-1:0] eff_height(input logic [CFG_BITS-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x == 0) x = 1;
    else if (x > MAX_HEIGHT) x = MAX_HEIGHT;
    return HGT_BITS'(x);
  endfunction

endpackage

### hdl/sgm_ram.sv
// generic simple dual port ram with registered read
module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hdl/sgm_cfg.sv
// apb register file for frame geometry
module sgm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [sgm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [sgm_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output sgm_pkg::geom_t                 geom
);
  import sgm_pkg::*;

  logic [CFG_BITS-1:0] image_width;
  logic [CFG_BITS-1:0] image_height;
  reg_idx_t            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_BITS'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign geom.width  = eff_width(image_width);
  assign geom.height = eff_height(image_height);

endmodule

### hdl/sgm_mag.sv
// sobel sums, clamping, squares and bit-serial square root
module sgm_mag (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sgm_pkg::win_t     window,
  output sgm_pkg::mag_res_t res
);
  import sgm_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_GRAD = 6'b000010,
    M_SQ   = 6'b000100,
    M_SUM  = 6'b001000,
    M_ROOT = 6'b010000,
    M_DONE = 6'b100000
  } mag_state_t;

  mag_state_t state;
  mag_state_t state_next;

  logic signed [GRAD_BITS-1:0] sx;
  logic signed [GRAD_BITS-1:0] sy;
  logic [PIX_BITS-1:0]         gx_n;
  logic [PIX_BITS-1:0]         gy_n;
  logic [PIX_BITS-1:0]         gx;
  logic [PIX_BITS-1:0]         gy;
  logic [2*PIX_BITS-1:0]       sq_x;
  logic [2*PIX_BITS-1:0]       sq_y;
  logic [2*PIX_BITS:0]         rad;
  logic [PIX_BITS-1:0]         root;
  logic [2:0]                  bit_idx;
  logic [PIX_BITS-1:0]         trial;
  logic [2*PIX_BITS-1:0]       trial_sq;

  always_comb begin
    sx = '0;
    sy = '0;
    for (int k = 0; k < 9; k++) begin
      sx = sx + GRAD_BITS'(signed'({1'b0, window[k]})) * GRAD_BITS'(MASK_X[k]);
      sy = sy + GRAD_BITS'(signed'({1'b0, window[k]})) * GRAD_BITS'(MASK_Y[k]);
    end
  end

  // negative sums go to zero, large ones saturate
  assign gx_n = sx[GRAD_BITS-1] ? '0 : ((|sx[GRAD_BITS-2:PIX_BITS]) ? '1 : sx[PIX_BITS-1:0]);
  assign gy_n = sy[GRAD_BITS-1] ? '0 : ((|sy[GRAD_BITS-2:PIX_BITS]) ? '1 : sy[PIX_BITS-1:0]);

  assign trial    = root | (PIX_BITS'(1) << bit_idx);
  assign trial_sq = {{PIX_BITS{1'b0}}, trial} * {{PIX_BITS{1'b0}}, trial};

  always_comb begin
    case (state)
      M_IDLE:  state_next = start ? M_GRAD : M_IDLE;
      M_GRAD:  state_next = M_SQ;
      M_SQ:    state_next = M_SUM;
      M_SUM:   state_next = M_ROOT;
      M_ROOT:  state_next = (rad[2*PIX_BITS] || bit_idx == '0) ? M_DONE : M_ROOT;
      M_DONE:  state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      M_GRAD: begin
        gx <= gx_n;
        gy <= gy_n;
      end
      M_SQ: begin
        sq_x <= {{PIX_BITS{1'b0}}, gx} * {{PIX_BITS{1'b0}}, gx};
        sq_y <= {{PIX_BITS{1'b0}}, gy} * {{PIX_BITS{1'b0}}, gy};
      end
      M_SUM: begin
        rad     <= {1'b0, sq_x} + {1'b0, sq_y};
        root    <= '0;
        bit_idx <= 3'd7;
      end
      M_ROOT: begin
        // at or above 256 squared the root saturates
        if (rad[2*PIX_BITS]) begin
          root <= '1;
        end else begin
          if (trial_sq <= rad[2*PIX_BITS-1:0]) root <= trial;
          bit_idx <= bit_idx - 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign res.done      = (state == M_DONE);
  assign res.magnitude = root;

endmodule

### hdl/sgm_ctrl.sv
// frame counters, line store access and window fetch sequencer
module sgm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [sgm_pkg::PIX_BITS-1:0] pixel,
  input  sgm_pkg::geom_t               geom,
  output logic                         mag_start,
  output sgm_pkg::win_t                window,
  input  sgm_pkg::mag_res_t            mag_res,
  output sgm_pkg::res_t                res,
  input  logic                         res_free
);
  import sgm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_LOAD  = 8'b00000010,
    ST_CLEAR = 8'b00000100,
    ST_WRITE = 8'b00001000,
    ST_FETCH = 8'b00010000,
    ST_CAPT  = 8'b00100000,
    ST_WAIT  = 8'b01000000,
    ST_DONE  = 8'b10000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic                accept;
  logic                req_q;
  logic [PIX_BITS-1:0] pixel_q;

  logic [HGT_BITS-1:0] input_row;
  logic [WID_BITS-1:0] input_col;
  logic [HGT_BITS-1:0] output_row;
  logic [WID_BITS-1:0] output_col;

  logic [IDX_BITS-1:0] in_count;
  logic [IDX_BITS-1:0] in_count_n;
  logic [IDX_BITS-1:0] out_idx;
  logic [IDX_BITS-1:0] total;
  logic [IDX_BITS-1:0] thr;
  logic [IDX_BITS-1:0] w_ext;

  logic                wrap;
  logic                wr_en;
  logic                ready;
  logic                last_out;

  logic [1:0]          fi;
  logic [1:0]          fj;
  logic                row_ok;
  logic                col_ok;
  logic                rd_en;
  logic                rd_pend;
  logic                rd_ok;
  logic [3:0]          cap_k;
  logic [LS_ABITS-1:0] ob;
  logic [LS_ABITS-1:0] wl;
  logic [LS_ABITS-1:0] ls_base;
  logic [LS_ABITS-1:0] rd_addr;
  logic [PIX_BITS-1:0] rd_data;
  logic [PIX_BITS-1:0] magnitude_q;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign w_ext      = IDX_BITS'(geom.width);
  assign wrap       = (out_idx >= total);
  assign wr_en      = (state == ST_WRITE) && !req_q && (in_count < total);
  assign in_count_n = in_count + IDX_BITS'(wr_en);
  assign ready      = (in_count_n >= total) || (in_count_n >= thr);
  assign last_out   = (IDX_BITS'(out_idx + IDX_BITS'(1)) == total);

  // neighbour addresses wrap in the line store like the raster index
  assign ob = out_idx[LS_ABITS-1:0];
  assign wl = LS_ABITS'(geom.width);

  always_comb begin
    case (fi)
      2'd0:    ls_base = ob - wl;
      2'd2:    ls_base = ob + wl;
      default: ls_base = ob;
    endcase
    case (fi)
      2'd0:    row_ok = (output_row != '0);
      2'd2:    row_ok = (HGT_BITS'(output_row + 1'b1) < geom.height);
      default: row_ok = 1'b1;
    endcase
    // the column may sit past the width after the geometry shrinks under a frame
    case (fj)
      2'd0:    col_ok = (output_col != '0) && (output_col <= geom.width);
      2'd2:    col_ok = (WID_BITS'(output_col + 1'b1) < geom.width);
      default: col_ok = (output_col < geom.width);
    endcase
  end

  assign rd_addr = ls_base + LS_ABITS'(fj) - LS_ABITS'(1);
  assign rd_en   = (state == ST_FETCH);

  sgm_ram #(
    .WIDTH(PIX_BITS),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_count[LS_ABITS-1:0]),
    .wdata(pixel_q),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    case (state)
      ST_IDLE:  state_next = accept ? ST_LOAD : ST_IDLE;
      ST_LOAD:  state_next = ST_CLEAR;
      ST_CLEAR: state_next = ST_WRITE;
      ST_WRITE: state_next = ready ? ST_FETCH : ST_IDLE;
      ST_FETCH: state_next = (fi == 2'd2 && fj == 2'd2) ? ST_CAPT : ST_FETCH;
      ST_CAPT:  state_next = ST_WAIT;
      ST_WAIT:  state_next = mag_res.done ? ST_DONE : ST_WAIT;
      ST_DONE:  state_next = res_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      input_row  <= '0;
      input_col  <= '0;
      output_row <= '0;
      output_col <= '0;
      rd_pend    <= 1'b0;
      cap_k      <= '0;
      fi         <= '0;
      fj         <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      rd_ok   <= row_ok && col_ok;
      // ram data arrives in the cycle after its read
      if (rd_pend) begin
        window[cap_k] <= rd_ok ? rd_data : '0;
        cap_k         <= cap_k + 4'd1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_q   <= req_type;
            pixel_q <= pixel;
          end
        end
        ST_LOAD: begin
          in_count <= IDX_BITS'(input_row) * w_ext + IDX_BITS'(input_col);
          out_idx  <= IDX_BITS'(output_row) * w_ext + IDX_BITS'(output_col);
          total    <= IDX_BITS'(geom.height) * w_ext;
        end
        ST_CLEAR: begin
          // next output outside the frame: abandon it
          if (wrap) begin
            input_row  <= '0;
            input_col  <= '0;
            output_row <= '0;
            output_col <= '0;
            in_count   <= '0;
            out_idx    <= '0;
            thr        <= w_ext + IDX_BITS'(2);
          end else begin
            thr <= out_idx + w_ext + IDX_BITS'(2);
          end
        end
        ST_WRITE: begin
          if (wr_en) begin
            in_count <= in_count_n;
            if (WID_BITS'(input_col + 1'b1) >= geom.width) begin
              input_col <= '0;
              input_row <= input_row + 1'b1;
            end else begin
              input_col <= input_col + 1'b1;
            end
          end
          fi    <= '0;
          fj    <= '0;
          cap_k <= '0;
        end
        ST_FETCH: begin
          if (fj == 2'd2) begin
            fj <= '0;
            fi <= fi + 2'd1;
          end else begin
            fj <= fj + 2'd1;
          end
        end
        ST_WAIT: begin
          if (mag_res.done) magnitude_q <= mag_res.magnitude;
        end
        ST_DONE: begin
          if (res_free) begin
            if (last_out) begin
              input_row  <= '0;
              input_col  <= '0;
              output_row <= '0;
              output_col <= '0;
            end else if (WID_BITS'(output_col + 1'b1) >= geom.width) begin
              output_col <= '0;
              output_row <= output_row + 1'b1;
            end else begin
              output_col <= output_col + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign mag_start     = (state == ST_CAPT);
  assign res.valid     = (state == ST_DONE);
  assign res.magnitude = magnitude_q;
  assign res.last      = last_out;

endmodule

### hdl/sobel_gradient_magnitude.sv
// top level: streaming 3x3 sobel gradient magnitude with apb geometry registers
//
// channel  dir  handshake                 payload
// in       in   in_valid / in_stall       req_type, pixel
// out      out  out_valid / out_stall     magnitude, last_of_frame
// cfg      in   psel, penable, pready     paddr, pwdata, prdata (pwrite)
//
// a transaction that yields no result passes through the load, clear and write states back to idle
// a transaction with a result takes nine line store reads through
// the single read port, then the gradient unit and its bit-serial 8-step square root
// the output register lets the next transaction in while a result waits on out_stall
// rst is synchronous; the line store has no clearing pass, entries are read only after
// being written within the current frame
module sobel_gradient_magnitude (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgm_pkg::PADDR_BITS-1:0] paddr,
  input  logic [sgm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [sgm_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [sgm_pkg::PIX_BITS-1:0]   pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sgm_pkg::PIX_BITS-1:0]   magnitude,
  output logic                           last_of_frame
);
  import sgm_pkg::*;

  geom_t    geom;
  logic     mag_start;
  win_t     window;
  mag_res_t mag_res;
  res_t     res;
  logic     res_free;

  sgm_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom   (geom)
  );

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .pixel    (pixel),
    .geom     (geom),
    .mag_start(mag_start),
    .window   (window),
    .mag_res  (mag_res),
    .res      (res),
    .res_free (res_free)
  );

  sgm_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (mag_start),
    .window(window),
    .res   (mag_res)
  );

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res.valid && res_free) begin
      magnitude     <= res.magnitude;
      last_of_frame <= res.last;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("new transaction taken while one is in progress");

  a_result_from_unit: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(mag_res.done))
    else $error("result offered without a finished magnitude");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_free) |=> (res.valid && $stable(res.magnitude) && $stable(res.last)))
    else $error("pending result changed before the output register took it");

endmodule
